[design/tws_pkg.sv]
`timescale 1ns / 1ps

package tws_pkg;

    localparam int CODE_W = 10;
    localparam int TEMP_W = 19;
    localparam int SCALE_W = 9;

    // code * 5 V * 100 deg/V / 1024 steps in q10 degrees
    localparam logic [SCALE_W-1:0] TEMP_SCALE = 9'd500;
    // 99.99 degrees in q10
    localparam logic [TEMP_W-1:0] MIN_RESET = 19'd102390;

    typedef struct packed {
        logic load_item;
        logic update;
        logic mult;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_stat;

endpackage

[design/temp_window_stats_top.sv]
`timescale 1ns / 1ps

// channel   direction  handshake          payload
// input     in         i_valid / o_ready  i_adc_code (10 b)
// result    out        o_valid / i_ready  o_current_temp, o_min_temp, o_max_temp,
//                                         o_avg_temp (19 b each, q10 degrees)
//
// one transaction at a time: accept, ring update, scale and min/max, then a
// restoring divide of sum*500 by the fill count at one bit a cycle, one step
// for each bit of the product, then a move to the load state once it is done
// the result sits in an output register; the next input transaction is taken
// while it waits, and a finished item waits in the load state until it drains
// synchronous active-low reset; no clearing pass, the fill count masks unwritten slots

module temp_window_stats_top #(
    parameter int WINDOW = 100
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [tws_pkg::CODE_W-1:0]  i_adc_code,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [tws_pkg::TEMP_W-1:0]  o_current_temp,
    output logic [tws_pkg::TEMP_W-1:0]  o_min_temp,
    output logic [tws_pkg::TEMP_W-1:0]  o_max_temp,
    output logic [tws_pkg::TEMP_W-1:0]  o_avg_temp
);

    // command and status between sequencer and datapath
    tws_pkg::t_cmd  cmd;
    tws_pkg::t_stat stat;

    // sequencer: owns the handshakes and the step order
    tws_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // datapath: sample ring, running sum, min/max, divider, output register
    tws_datapath #(
        .WINDOW (WINDOW)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_adc_code     (i_adc_code),
        .o_current_temp (o_current_temp),
        .o_min_temp     (o_min_temp),
        .o_max_temp     (o_max_temp),
        .o_avg_temp     (o_avg_temp)
    );

endmodule

[design/tws_ctrl.sv]
`timescale 1ns / 1ps

module tws_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  tws_pkg::t_stat i_stat,
    output tws_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_MULT,
        S_DIV,
        S_LOAD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state = S_MULT;
            end
            S_MULT: begin
                o_cmd.mult = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_LOAD;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_LOAD: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

endmodule

[design/tws_datapath.sv]
`timescale 1ns / 1ps

module tws_datapath #(
    parameter int WINDOW = 100
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tws_pkg::t_cmd               i_cmd,
    output tws_pkg::t_stat              o_stat,
    input  logic [tws_pkg::CODE_W-1:0]  i_adc_code,
    output logic [tws_pkg::TEMP_W-1:0]  o_current_temp,
    output logic [tws_pkg::TEMP_W-1:0]  o_min_temp,
    output logic [tws_pkg::TEMP_W-1:0]  o_max_temp,
    output logic [tws_pkg::TEMP_W-1:0]  o_avg_temp
);

    localparam int CODE_W = tws_pkg::CODE_W;
    localparam int TEMP_W = tws_pkg::TEMP_W;
    localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = $clog2(WINDOW * ((1 << CODE_W) - 1) + 1);
    localparam int PROD_W = SUM_W + tws_pkg::SCALE_W;
    localparam int STEP_W = $clog2(PROD_W + 1);

    logic [CODE_W-1:0] r_ring [WINDOW];
    logic [CODE_W-1:0] r_rd_data;
    logic [CODE_W-1:0] r_code;
    logic [IDX_W-1:0]  r_wr_idx;
    logic [FILL_W-1:0] r_fill;
    logic [SUM_W-1:0]  r_sum;
    logic [TEMP_W-1:0] r_temp;
    logic [TEMP_W-1:0] r_lowest;
    logic [TEMP_W-1:0] r_highest;
    logic [FILL_W-1:0] r_rem;
    logic [PROD_W-1:0] r_quo;
    logic [STEP_W-1:0] r_step;

    logic              window_full;
    logic [CODE_W-1:0] old_code;
    logic [FILL_W:0]   shifted;
    logic              fits;
    logic [FILL_W-1:0] n_rem;

    // slots past the fill point were never written and count as zero
    assign window_full = (r_fill == FILL_W'(WINDOW));
    assign old_code    = window_full ? r_rd_data : '0;

    // one restoring division step per cycle
    assign shifted = {r_rem, r_quo[PROD_W-1]};
    assign fits    = (shifted >= {1'b0, r_fill});
    assign n_rem   = fits ? FILL_W'(shifted - {1'b0, r_fill}) : shifted[FILL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_rd_data <= r_ring[r_wr_idx];
        end
        if (i_cmd.update) begin
            r_ring[r_wr_idx] <= r_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx  <= '0;
            r_fill    <= '0;
            r_sum     <= '0;
            r_lowest  <= tws_pkg::MIN_RESET;
            r_highest <= '0;
            r_step    <= '0;
        end else begin
            if (i_cmd.update) begin
                r_sum <= r_sum + SUM_W'(r_code) - SUM_W'(old_code);
                r_wr_idx <= (r_wr_idx == IDX_W'(WINDOW - 1)) ? '0 : r_wr_idx + 1'b1;
                if (!window_full) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (i_cmd.mult) begin
                if (r_temp < r_lowest) begin
                    r_lowest <= r_temp;
                end
                if (r_temp > r_highest) begin
                    r_highest <= r_temp;
                end
                r_step <= '0;
            end else if (i_cmd.div_step) begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_code <= i_adc_code;
        end
        if (i_cmd.update) begin
            r_temp <= TEMP_W'(r_code) * TEMP_W'(tws_pkg::TEMP_SCALE);
        end
        if (i_cmd.mult) begin
            r_quo <= PROD_W'(r_sum) * PROD_W'(tws_pkg::TEMP_SCALE);
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[PROD_W-2:0], fits};
            r_rem <= n_rem;
        end
        if (i_cmd.load_out) begin
            o_current_temp <= r_temp;
            o_min_temp     <= r_lowest;
            o_max_temp     <= r_highest;
            o_avg_temp     <= TEMP_W'(r_quo);
        end
    end

    assign o_stat.div_done = (r_step == STEP_W'(PROD_W));

endmodule

[design/tws_checker.sv]
`timescale 1ns / 1ps

module tws_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_ready,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [tws_pkg::TEMP_W-1:0]  o_current_temp,
    input logic [tws_pkg::TEMP_W-1:0]  o_min_temp,
    input logic [tws_pkg::TEMP_W-1:0]  o_max_temp,
    input logic [tws_pkg::TEMP_W-1:0]  o_avg_temp
);

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_current_temp)
            && $stable(o_min_temp) && $stable(o_max_temp) && $stable(o_avg_temp))
        else $error("result changed while stalled");

    // extremes bracket the current sample
    a_bracket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_min_temp <= o_current_temp) && (o_current_temp <= o_max_temp))
        else $error("min/max do not bracket current temperature");

    // one transaction in flight: busy right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input taken again while busy");

    // nothing comes out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

endmodule

bind temp_window_stats_top tws_checker u_tws_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_current_temp (o_current_temp),
    .o_min_temp     (o_min_temp),
    .o_max_temp     (o_max_temp),
    .o_avg_temp     (o_avg_temp)
);

[sim/tb_temp_window_stats_top.sv]
`timescale 1ns / 1ps

module tb_temp_window_stats_top;

    localparam int CODE_W = tws_pkg::CODE_W;
    localparam int TEMP_W = tws_pkg::TEMP_W;

    // block configuration and the arithmetic it is expected to follow
    localparam int WINDOW = 100;
    localparam int unsigned DEG_SCALE = 500;         // code * 500 = q10 degrees
    localparam int unsigned LOWEST_AT_RESET = 102390; // 99.99 degrees in q10
    localparam int unsigned SUM_MASK = 32'h1FFFF;    // 17-bit running sum
    localparam int unsigned TEMP_MASK = 32'h7FFFF;   // 19-bit result fields

    // run length and guard limits
    localparam int RANDOM_PER_MIX = 534;   // three mixes, at least 534 codes each
    localparam int SETTLE_CYCLES = 64;     // quiet stretch after the last result comes back
    localparam int STALL_LIMIT = 2000;     // cycles with no transaction on either side

    // idle mixes applied to both channels, in run order
    typedef enum logic [1:0] {
        MIX_SLOW_SINK,     // sender idles 38 %, receiver 61 %
        MIX_SLOW_SOURCE,   // sender idles 61 %, receiver 38 %
        MIX_NO_IDLE        // both sides at full rate
    } t_idle_mix;

    // shapes of the random code streams
    typedef enum logic [1:0] {
        RUN_UNIFORM,
        RUN_DRIFT,
        RUN_STEADY,
        RUN_EXTREME
    } t_run_shape;

    typedef struct {
        logic [CODE_W-1:0] code;
        logic              hold_for_drain;  // wait for every result before sending
        t_idle_mix         mix;
    } t_code_req;

    typedef struct {
        logic [TEMP_W-1:0] current_temp;
        logic [TEMP_W-1:0] min_temp;
        logic [TEMP_W-1:0] max_temp;
        logic [TEMP_W-1:0] avg_temp;
    } t_temp_stats;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [CODE_W-1:0] i_adc_code;
    logic              o_valid;
    logic              i_ready;
    logic [TEMP_W-1:0] o_current_temp;
    logic [TEMP_W-1:0] o_min_temp;
    logic [TEMP_W-1:0] o_max_temp;
    logic [TEMP_W-1:0] o_avg_temp;

    temp_window_stats_top #(
        .WINDOW(WINDOW)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_adc_code     (i_adc_code),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_current_temp (o_current_temp),
        .o_min_temp     (o_min_temp),
        .o_max_temp     (o_max_temp),
        .o_avg_temp     (o_avg_temp)
    );

    // stimulus waiting to go out, and statistics waiting to come back
    t_code_req   codes_to_send[$];
    t_temp_stats stats_due[$];

    // private copy of the window state, advanced once per accepted code
    logic [CODE_W-1:0] code_ring[WINDOW];
    int unsigned       ring_slot;
    int unsigned       ring_fill;
    int unsigned       code_sum;
    int unsigned       lowest_temp;
    int unsigned       highest_temp;

    t_idle_mix   cur_mix;
    int unsigned codes_queued;
    int unsigned codes_taken;
    int unsigned mismatch_count;
    int unsigned stall_cycles;

    // 4 ns clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic int unsigned send_idle_pct(t_idle_mix mix);
        case (mix)
            MIX_SLOW_SINK:   return 38;
            MIX_SLOW_SOURCE: return 61;
            default:         return 0;
        endcase
    endfunction

    function automatic int unsigned recv_idle_pct(t_idle_mix mix);
        case (mix)
            MIX_SLOW_SINK:   return 61;
            MIX_SLOW_SOURCE: return 38;
            default:         return 0;
        endcase
    endfunction

    // fold one code into the window and queue the statistics it must produce
    task automatic compute_temp_stats(input logic [CODE_W-1:0] code);
        int unsigned temp;
        t_temp_stats due;
        begin
            temp = int'(code) * DEG_SCALE;
            // oldest code leaves the sum once the ring has wrapped; unwritten
            // slots hold zero so the subtraction is harmless while filling
            code_sum = (code_sum + int'(code) - int'(code_ring[ring_slot])) & SUM_MASK;
            code_ring[ring_slot] = code;
            ring_slot = (ring_slot == WINDOW - 1) ? 0 : ring_slot + 1;
            if (ring_fill < WINDOW) begin
                ring_fill++;
            end
            // strict compares: equal readings leave the extremes alone
            if (temp < lowest_temp) begin
                lowest_temp = temp;
            end
            if (temp > highest_temp) begin
                highest_temp = temp;
            end
            due.current_temp = TEMP_W'(temp & TEMP_MASK);
            due.min_temp     = TEMP_W'(lowest_temp & TEMP_MASK);
            due.max_temp     = TEMP_W'(highest_temp & TEMP_MASK);
            due.avg_temp     = TEMP_W'(((code_sum * DEG_SCALE) / ring_fill) & TEMP_MASK);
            stats_due.push_back(due);
        end
    endtask

    task automatic check_field(input string name, input logic [TEMP_W-1:0] got,
                               input logic [TEMP_W-1:0] want);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic queue_code(input int unsigned code, input logic hold, input t_idle_mix mix);
        t_code_req req;
        begin
            req.code = CODE_W'(code);
            req.hold_for_drain = hold;
            req.mix = mix;
            codes_to_send.push_back(req);
            codes_queued++;
        end
    endtask

    // driver: accounts for the transaction taken at this edge, then decides
    // what i_valid carries into the next cycle (one nonblocking write at most)
    always @(posedge i_clk) begin : source_drive
        t_code_req nxt;
        logic      launch;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            launch = 1'b0;
            if (i_valid && o_ready) begin
                compute_temp_stats(i_adc_code);
                codes_taken <= codes_taken + 1;
            end
            // free to present a new code when nothing is held or it just went
            if (!i_valid || o_ready) begin
                if (codes_to_send.size() != 0) begin
                    nxt = codes_to_send[0];
                    // a hold item stays back until the result side is empty
                    if (!(nxt.hold_for_drain && stats_due.size() != 0)
                        && $urandom_range(99) >= send_idle_pct(nxt.mix)) begin
                        launch = 1'b1;
                    end
                end
                if (launch) begin
                    void'(codes_to_send.pop_front());
                    i_valid    <= 1'b1;
                    i_adc_code <= nxt.code;
                    cur_mix    <= nxt.mix;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: every result is matched against the oldest expectation,
    // then i_ready is redrawn for the next cycle
    always @(posedge i_clk) begin : sink_check
        t_temp_stats due;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (stats_due.size() == 0) begin
                    $error("unexpected result: cur %0d min %0d max %0d avg %0d",
                           o_current_temp, o_min_temp, o_max_temp, o_avg_temp);
                    mismatch_count++;
                end else begin
                    due = stats_due.pop_front();
                    check_field("current_temp", o_current_temp, due.current_temp);
                    check_field("min_temp", o_min_temp, due.min_temp);
                    check_field("max_temp", o_max_temp, due.max_temp);
                    check_field("avg_temp", o_avg_temp, due.avg_temp);
                end
            end
            i_ready <= ($urandom_range(99) >= recv_idle_pct(cur_mix));
        end
    end

    // watchdog: a hang shows up as a long run of cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("temp_window_stats_top regression: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : run_ctrl
        t_run_shape shape;
        int         run_len;
        int         level;
        int         step;
        int         n;
        t_idle_mix  mix;
        logic       hold;

        // every block input known from time zero, reset held low
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_ready      = 1'b0;
        i_adc_code   = '0;
        cur_mix      = MIX_SLOW_SINK;
        codes_queued = 0;
        codes_taken  = 0;
        mismatch_count = 0;
        stall_cycles = 0;
        foreach (code_ring[k]) begin
            code_ring[k] = '0;
        end
        ring_slot    = 0;
        ring_fill    = 0;
        code_sum     = 0;
        lowest_temp  = LOWEST_AT_RESET;
        highest_temp = 0;

        // directed codes
        // just above 99.99 degrees: min keeps its reset value, max rises
        queue_code(205, 1'b0, MIX_SLOW_SINK);
        // just below: first real lowering of the minimum
        queue_code(204, 1'b0, MIX_SLOW_SINK);
        queue_code(1023, 1'b0, MIX_SLOW_SINK);
        queue_code(1023, 1'b0, MIX_SLOW_SINK);   // equal to max, no update
        queue_code(0, 1'b0, MIX_SLOW_SINK);
        queue_code(0, 1'b0, MIX_SLOW_SINK);      // equal to min, no update
        queue_code(10'h155, 1'b0, MIX_SLOW_SINK);
        queue_code(10'h2AA, 1'b1, MIX_SLOW_SINK); // sent only once the block is empty
        queue_code(1, 1'b0, MIX_SLOW_SINK);
        queue_code(512, 1'b0, MIX_SLOW_SINK);
        queue_code(511, 1'b0, MIX_SLOW_SINK);
        queue_code(1022, 1'b0, MIX_SLOW_SINK);
        queue_code(204, 1'b0, MIX_SLOW_SINK);
        queue_code(205, 1'b0, MIX_SLOW_SINK);
        queue_code(1023, 1'b0, MIX_SLOW_SINK);
        queue_code(3, 1'b0, MIX_SLOW_SINK);

        // random streams, one block of codes per idle mix; the window fills and
        // wraps many times over, so the full-window subtraction is exercised
        for (int m = 0; m < 3; m++) begin
            mix = t_idle_mix'(m);
            n = 0;
            level = $urandom_range(1023);
            while (n < RANDOM_PER_MIX) begin
                shape = t_run_shape'($urandom_range(3));
                run_len = $urandom_range(60, 8);
                for (int j = 0; j < run_len; j++) begin
                    // a drain pause opens each mix, plus the odd one mid-stream
                    hold = (n == 0) || ($urandom_range(199) == 0);
                    case (shape)
                        RUN_UNIFORM: level = $urandom_range(1023);
                        RUN_DRIFT: begin
                            // slowly wandering sensor reading
                            step = int'($urandom_range(16)) - 8;
                            level = level + step;
                            if (level < 0) level = 0;
                            if (level > 1023) level = 1023;
                        end
                        RUN_STEADY: begin
                            if (j == 0) level = $urandom_range(1023);
                        end
                        default: begin
                            case ($urandom_range(3))
                                0: level = 0;
                                1: level = 1023;
                                2: level = 204;
                                default: level = 205;
                            endcase
                        end
                    endcase
                    queue_code(level, hold, mix);
                    n++;
                end
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all codes taken, every result back, then a quiet stretch to catch
        // anything extra the block might still emit
        while (codes_taken != codes_queued) @(posedge i_clk);
        while (stats_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("temp_window_stats_top regression: pass");
        end else begin
            $display("temp_window_stats_top regression: fail");
        end
        $finish;
    end

endmodule
